// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL. They are empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/mmcs_pkg.sv =====
// ----------------------------------------------------------------------------
// mmcs_pkg
// Shared types and constants of the min-max contrast stretch block.
// ----------------------------------------------------------------------------
package mmcs_pkg;

    // Default grey-level width.
    localparam int unsigned PIXEL_BITS_DEF = 8;

    // Operation codes carried by an input item.
    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_OBSERVE = 2'd1,
        OP_MAP     = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    // Configuration register indexes.
    typedef enum logic {
        REG_OUT_MIN = 1'b0,
        REG_OUT_MAX = 1'b1
    } t_reg_idx;

endpackage

// ===== src/min_max_contrast_stretch_top.sv =====
// ----------------------------------------------------------------------------
// min_max_contrast_stretch_top
// Two-pass linear contrast stretch of grey-level pixels.
//
// The input channel carries an operation and a pixel. A clear transfer empties
// the lowest/highest statistics, an observe transfer folds the pixel into them,
// and a map transfer returns one result on the output channel:
//   out_min + floor((out_max-out_min)*(p-low)/(high-low) + 1/2), saturated.
// When nothing was observed or the range is a single level the result is
// out_min with flat_range set. Clear, observe and unused codes give no result.
// The user must write out_min and out_max through the configuration port only
// while idle; the block itself does not enforce it. Clear and observe leave the
// block idle, so it is ready again at once. A flat map shows its result in the
// cycle after the transfer. Any other map steps through a multiply, a setup,
// the passes of the shared restoring divide subtractor, and a rounding and
// saturation state. The input is not ready while an item is in work or its
// result waits; a stalled receiver simply holds the result.
// Reset restores out_min = 0, out_max = full scale and empty statistics.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module min_max_contrast_stretch_top #(
    parameter int unsigned PIXEL_BITS = mmcs_pkg::PIXEL_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  mmcs_pkg::t_reg_idx    i_cfg_index,
    input  logic [PIXEL_BITS-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  mmcs_pkg::t_op         i_operation,
    input  logic [PIXEL_BITS-1:0] i_pixel,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [PIXEL_BITS-1:0] o_mapped_pixel,
    output logic                  o_flat_range
);
    import mmcs_pkg::*;

    localparam int unsigned W  = PIXEL_BITS;
    localparam int unsigned PW = 2 * W + 2;      // product width
    localparam int unsigned NW = 2 * W + 3;      // rounded numerator width
    localparam int unsigned QW = NW - 1;         // dividend / quotient width
    localparam int unsigned DW = W + 1;          // divisor width
    localparam int unsigned CW = $clog2(QW + 1);
    localparam logic [W-1:0] PIX_MAX = {W{1'b1}};

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MUL  = 6'b000010,
        ST_PREP = 6'b000100,
        ST_DIV  = 6'b001000,
        ST_FIX  = 6'b010000,
        ST_OUT  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [W-1:0]         r_out_min, r_out_max;
    logic [W-1:0]         r_low, r_high;
    logic                 r_any;
    logic [W-1:0]         r_pix;
    logic signed [PW-1:0] r_prod;
    logic                 r_neg;
    logic [DW-1:0]        r_divisor;
    logic [DW-1:0]        r_rem;
    logic [QW-1:0]        r_quo;
    logic [CW-1:0]        r_cnt;
    logic [W-1:0]         r_mapped;
    logic                 r_flat;

    logic                 s_in_xfer;
    logic                 s_is_flat;
    logic signed [W:0]    s_span, s_dist;
    logic signed [PW-1:0] s_prod;
    logic [W-1:0]         s_range;
    logic [NW-1:0]        s_num;
    logic [NW-1:0]        s_num_abs;
    logic [DW:0]          s_trial;
    logic                 s_ge;
    logic [DW:0]          s_diff;
    logic [NW-1:0]        s_q;
    logic [NW:0]          s_v;
    logic [W-1:0]         s_sat;

    assign o_in_ready     = (r_state == ST_IDLE);
    assign o_out_valid    = (r_state == ST_OUT);
    assign o_mapped_pixel = r_mapped;
    assign o_flat_range   = r_flat;

    assign s_in_xfer = i_in_valid && o_in_ready;
    assign s_is_flat = !r_any || (r_high <= r_low);

    // Signed span of the output scale and distance of the pixel from the low level.
    assign s_span  = $signed({1'b0, r_out_max}) - $signed({1'b0, r_out_min});
    assign s_dist  = $signed({1'b0, r_pix}) - $signed({1'b0, r_low});
    assign s_prod  = PW'(s_span) * PW'(s_dist);
    assign s_range = r_high - r_low;

    // Numerator 2*num + r; the divisor is 2*r, so the quotient is the rounded value.
    assign s_num     = {r_prod, 1'b0} + NW'(s_range);
    assign s_num_abs = s_num[NW-1] ? (~s_num + NW'(1)) : s_num;

    // One restoring step of the shared subtractor.
    assign s_trial = {r_rem, r_quo[QW-1]};
    assign s_ge    = (s_trial >= (DW+1)'(r_divisor));
    assign s_diff  = s_trial - (DW+1)'(r_divisor);

    // Floor of a negative quotient rounds away from zero when a remainder is left.
    always_comb begin
        if (r_neg) begin
            s_q = ~(NW'(r_quo) + NW'(r_rem != '0)) + NW'(1);
        end else begin
            s_q = NW'(r_quo);
        end
        s_v = {s_q[NW-1], s_q} + (NW+1)'(r_out_min);
        if (s_v[NW]) begin
            s_sat = '0;
        end else if (s_v[NW-1:0] > NW'(PIX_MAX)) begin
            s_sat = PIX_MAX;
        end else begin
            s_sat = s_v[W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_in_xfer && i_operation == OP_MAP) begin
                    n_state = s_is_flat ? ST_OUT : ST_MUL;
                end
            end
            ST_MUL:  n_state = ST_PREP;
            ST_PREP: n_state = ST_DIV;
            ST_DIV: begin
                if (r_cnt == CW'(1)) begin
                    n_state = ST_FIX;
                end
            end
            ST_FIX:  n_state = ST_OUT;
            ST_OUT: begin
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control state, configuration and statistics.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_out_min <= '0;
            r_out_max <= PIX_MAX;
            r_low     <= '0;
            r_high    <= '0;
            r_any     <= 1'b0;
            r_cnt     <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_OUT_MIN: r_out_min <= i_cfg_data;
                    REG_OUT_MAX: r_out_max <= i_cfg_data;
                    default:     r_out_min <= r_out_min;
                endcase
            end
            if (s_in_xfer) begin
                case (i_operation)
                    OP_CLEAR: begin
                        r_low  <= '0;
                        r_high <= '0;
                        r_any  <= 1'b0;
                    end
                    OP_OBSERVE: begin
                        r_any <= 1'b1;
                        if (!r_any || i_pixel < r_low) begin
                            r_low <= i_pixel;
                        end
                        if (!r_any || i_pixel > r_high) begin
                            r_high <= i_pixel;
                        end
                    end
                    default: r_any <= r_any;
                endcase
            end
            if (r_state == ST_PREP) begin
                r_cnt <= CW'(QW);
            end else if (r_state == ST_DIV) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (s_in_xfer) begin
            r_pix    <= i_pixel;
            r_mapped <= r_out_min;
            r_flat   <= 1'b1;
        end
        if (r_state == ST_MUL) begin
            r_prod <= s_prod;
        end
        if (r_state == ST_PREP) begin
            r_neg     <= s_num[NW-1];
            r_quo     <= s_num_abs[QW-1:0];
            r_rem     <= '0;
            r_divisor <= {s_range, 1'b0};
        end
        if (r_state == ST_DIV) begin
            r_rem <= s_ge ? s_diff[DW-1:0] : s_trial[DW-1:0];
            r_quo <= {r_quo[QW-2:0], s_ge};
        end
        if (r_state == ST_FIX) begin
            r_mapped <= s_sat;
            r_flat   <= 1'b0;
        end
    end

    `ASSERT_IMPLIES(a_ready_excl, i_clk, i_rst_n, o_out_valid, !o_in_ready)
    `ASSERT_IMPLIES(a_flat_is_min, i_clk, i_rst_n, o_out_valid && r_flat, r_mapped == r_out_min)
    `ASSERT_NEXT(a_map_busy, i_clk, i_rst_n, s_in_xfer && i_operation == OP_MAP, !o_in_ready)
    `ASSERT_IMPLIES(a_div_count, i_clk, i_rst_n, r_state == ST_DIV, r_cnt != '0)

endmodule
